// ----- hw/rtl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and widths for the point-in-polygon crossing-number test.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Signed Q12.12 coordinates
  localparam int COORD_BITS = 24;
  // Coordinate differences and their products
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One vertex request
  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    coord_t point_x;
    coord_t point_y;
    logic   first_vertex;
    logic   last_vertex;
  } pip_in_t;

  // One result
  typedef struct packed {
    logic inside_res;
    logic on_boundary;
  } pip_out_t;

  // Registered vertex with everything both edge tests need
  typedef struct packed {
    coord_t vx;
    coord_t vy;
    coord_t prev_x;
    coord_t prev_y;
    coord_t start_x;
    coord_t start_y;
    coord_t held_px;
    coord_t held_py;
    logic   first;
    logic   last;
  } pip_ctx_t;

  // Outcome of one edge against the held point
  typedef struct packed {
    logic crossed;
    logic hit;
  } pip_edge_res_t;

endpackage

// ----- hw/rtl/pip_edge_test.sv -----
// ----------------------------------------------------------------------------
// pip_edge_test
// Ray crossing and exact on-segment check of one edge (xi,yi)-(xj,yj).
// ----------------------------------------------------------------------------
module pip_edge_test (
  input  pip_pkg::coord_t        xi,
  input  pip_pkg::coord_t        yi,
  input  pip_pkg::coord_t        xj,
  input  pip_pkg::coord_t        yj,
  input  pip_pkg::coord_t        tx,
  input  pip_pkg::coord_t        ty,
  output pip_pkg::pip_edge_res_t res
);

  logic signed [pip_pkg::DIFF_BITS-1:0] dx;
  logic signed [pip_pkg::DIFF_BITS-1:0] dy;
  logic signed [pip_pkg::DIFF_BITS-1:0] tdx;
  logic signed [pip_pkg::DIFF_BITS-1:0] tdy;
  logic signed [pip_pkg::PROD_BITS-1:0] lhs;
  logic signed [pip_pkg::PROD_BITS-1:0] rhs;
  logic                                 in_box;
  logic                                 straddle;

  assign dx  = pip_pkg::DIFF_BITS'(xj) - pip_pkg::DIFF_BITS'(xi);
  assign dy  = pip_pkg::DIFF_BITS'(yj) - pip_pkg::DIFF_BITS'(yi);
  assign tdx = pip_pkg::DIFF_BITS'(tx) - pip_pkg::DIFF_BITS'(xi);
  assign tdy = pip_pkg::DIFF_BITS'(ty) - pip_pkg::DIFF_BITS'(yi);

  assign lhs = tdx * dy;
  assign rhs = dx * tdy;

  assign in_box = ((tx >= xi && tx <= xj) || (tx >= xj && tx <= xi)) &&
                  ((ty >= yi && ty <= yj) || (ty >= yj && ty <= yi));

  assign straddle = (yi > ty) != (yj > ty);

  // Sign of dy picks the direction of the cross-multiplied compare
  assign res.hit     = (lhs == rhs) && in_box;
  assign res.crossed = straddle && ((dy > 0) ? (lhs < rhs) : (rhs < lhs));

endmodule

// ----- hw/rtl/pip_front.sv -----
// ----------------------------------------------------------------------------
// pip_front
// Input register: holds the accepted vertex with its previous vertex, the
// polygon's first vertex and the latched test point.
// ----------------------------------------------------------------------------
module pip_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              vtx_valid,
  output logic              vtx_ready,
  input  pip_pkg::pip_in_t  vtx,
  input  logic              advance,
  output logic              valid,
  output pip_pkg::pip_ctx_t ctx
);

  logic take;

  assign vtx_ready = !valid || advance;
  assign take      = vtx_valid && vtx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      ctx   <= '0;
    end else begin
      if (take) begin
        valid       <= 1'b1;
        ctx.vx      <= vtx.vertex_x;
        ctx.vy      <= vtx.vertex_y;
        // previous vertex is the one held until now
        ctx.prev_x  <= ctx.vx;
        ctx.prev_y  <= ctx.vy;
        ctx.first   <= vtx.first_vertex;
        ctx.last    <= vtx.last_vertex;
        if (vtx.first_vertex) begin
          ctx.start_x <= vtx.vertex_x;
          ctx.start_y <= vtx.vertex_y;
          ctx.held_px <= vtx.point_x;
          ctx.held_py <= vtx.point_y;
        end
      end else if (advance) begin
        valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/point_in_polygon_test_core.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// Even-odd point-in-polygon test over a vertex stream, one vertex a cycle unless a result is held.
// ----------------------------------------------------------------------------
// Path: input register, then the parity/result registers.
// Throughput: 1 vertex per cycle, but a last vertex waits while an untaken
//   result is held; both edge tests of a vertex run combinationally in between.
// Reset: clears the pipeline valids, the stored vertices, the latched point,
//   the crossing parity and the boundary flag; ready is high after reset.
module point_in_polygon_test_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              vtx_valid,
  output logic              vtx_ready,
  input  pip_pkg::pip_in_t  vtx,
  output logic              res_valid,
  input  logic              res_ready,
  output pip_pkg::pip_out_t res
);

  logic                  ctx_valid;
  pip_pkg::pip_ctx_t     ctx;
  logic                  advance;
  pip_pkg::pip_edge_res_t edge_prev;
  pip_pkg::pip_edge_res_t edge_close;
  logic                  parity;
  logic                  hit;
  logic                  parity_next;
  logic                  hit_next;

  // Hold a last vertex while an untaken result sits in the output register
  assign advance = ctx_valid && (!ctx.last || !res_valid || res_ready);

  pip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .advance   (advance),
    .valid     (ctx_valid),
    .ctx       (ctx)
  );

  // Edge from this vertex back to the previous one
  pip_edge_test u_edge_prev (
    .xi  (ctx.vx),
    .yi  (ctx.vy),
    .xj  (ctx.prev_x),
    .yj  (ctx.prev_y),
    .tx  (ctx.held_px),
    .ty  (ctx.held_py),
    .res (edge_prev)
  );

  // Closing edge from the first vertex to this one
  pip_edge_test u_edge_close (
    .xi  (ctx.start_x),
    .yi  (ctx.start_y),
    .xj  (ctx.vx),
    .yj  (ctx.vy),
    .tx  (ctx.held_px),
    .ty  (ctx.held_py),
    .res (edge_close)
  );

  always_comb begin
    parity_next = (parity && !ctx.first)
                ^ (edge_prev.crossed && !ctx.first)
                ^ (edge_close.crossed && ctx.last);
    hit_next    = (hit && !ctx.first)
                || (edge_prev.hit && !ctx.first)
                || (edge_close.hit && ctx.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity    <= 1'b0;
      hit       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (advance) begin
        parity <= parity_next;
        hit    <= hit_next;
      end
      if (advance && ctx.last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctx.last) begin
      res.inside_res  <= parity_next || hit_next;
      res.on_boundary <= hit_next;
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Vertex-stream test of point_in_polygon_test_core: directed polygons, then
// random polygons and noise under several idle patterns and a result hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int              ONE        = 4096;     // 1.0 in Q12.12
  localparam pip_pkg::coord_t C_MAX      =
    pip_pkg::coord_t'((1 <<< (pip_pkg::COORD_BITS - 1)) - 1);
  localparam pip_pkg::coord_t C_MIN      = ~C_MAX;
  localparam int              CYCLE_CAP  = 200000;
  localparam int              HOLD_LEN   = 300;

  localparam int MODE_FULL = 0;
  localparam int MODE_GRID = 1;
  localparam int MODE_TINY = 2;

  // Tracks the even-odd state of the vertex stream and the verdicts it owes
  class crossing_tracker;
    longint            start_x, start_y, prev_x, prev_y, held_px, held_py;
    bit                parity, hit;
    pip_pkg::pip_out_t verdicts_due[$];
    int                errors, verdicts_seen, hits_seen;

    function new();
      start_x = 0; start_y = 0; prev_x = 0; prev_y = 0;
      held_px = 0; held_py = 0;
      parity = 0; hit = 0;
      errors = 0; verdicts_seen = 0; hits_seen = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // edge (xi,yi)-(xj,yj) against the held point; 50-bit products fit longint
    function void edge_test(longint xi, longint yi, longint xj, longint yj);
      longint dx, dy, lhs, rhs;
      bit     crosses;
      dx  = xj - xi;
      dy  = yj - yi;
      lhs = (held_px - xi) * dy;
      rhs = dx * (held_py - yi);
      if (lhs == rhs &&
          held_px >= ((xi < xj) ? xi : xj) && held_px <= ((xi < xj) ? xj : xi) &&
          held_py >= ((yi < yj) ? yi : yj) && held_py <= ((yi < yj) ? yj : yi))
        hit = 1'b1;
      if ((yi > held_py) != (yj > held_py)) begin
        crosses = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
        if (crosses)
          parity = ~parity;
      end
    endfunction

    function void take_vertex(pip_pkg::pip_in_t v);
      longint            vx, vy;
      pip_pkg::pip_out_t verdict;
      vx = longint'($signed(v.vertex_x));
      vy = longint'($signed(v.vertex_y));
      if (v.first_vertex) begin
        held_px = longint'($signed(v.point_x));
        held_py = longint'($signed(v.point_y));
        start_x = vx;
        start_y = vy;
        parity  = 1'b0;
        hit     = 1'b0;
      end else begin
        edge_test(vx, vy, prev_x, prev_y);
      end
      if (v.last_vertex)
        edge_test(start_x, start_y, vx, vy);
      prev_x = vx;
      prev_y = vy;
      if (v.last_vertex) begin
        verdict.inside_res  = parity | hit;
        verdict.on_boundary = hit;
        verdicts_due.push_back(verdict);
      end
    endfunction

    task check_verdict(pip_pkg::pip_out_t got);
      pip_pkg::pip_out_t want;
      if (verdicts_due.size() == 0) begin
        report($sformatf("result %b with none outstanding", got));
        return;
      end
      want = verdicts_due.pop_front();
      verdicts_seen++;
      if (want.on_boundary)
        hits_seen++;
      if (got.inside_res !== want.inside_res)
        report($sformatf("inside_res got %b want %b", got.inside_res, want.inside_res));
      if (got.on_boundary !== want.on_boundary)
        report($sformatf("on_boundary got %b want %b", got.on_boundary, want.on_boundary));
    endtask

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              vtx_valid;
  logic              vtx_ready;
  pip_pkg::pip_in_t  vtx;
  logic              res_valid;
  logic              res_ready;
  pip_pkg::pip_out_t res;

  crossing_tracker sb;
  int  send_idle_pct;
  int  res_stall_pct;
  bit  hold_res;
  int  cycles;
  int  vertices_sent;

  point_in_polygon_test_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, plus the long hold-off when requested
  always @(negedge clk)
    res_ready <= !hold_res && ($urandom_range(99) >= res_stall_pct);

  always @(posedge clk)
    if (!rst && res_valid && res_ready)
      sb.check_verdict(res);

  function automatic pip_pkg::pip_in_t mk(int vx, int vy, int px, int py, bit first,
                                          bit last);
    pip_pkg::pip_in_t v;
    v.vertex_x     = pip_pkg::coord_t'(vx);
    v.vertex_y     = pip_pkg::coord_t'(vy);
    v.point_x      = pip_pkg::coord_t'(px);
    v.point_y      = pip_pkg::coord_t'(py);
    v.first_vertex = first;
    v.last_vertex  = last;
    return v;
  endfunction

  function automatic pip_pkg::coord_t rand_coord(int mode);
    case (mode)
      MODE_GRID: return pip_pkg::coord_t'((int'($urandom_range(16)) - 8) * ONE);
      MODE_TINY: return pip_pkg::coord_t'(int'($urandom_range(6)) - 3);
      default: begin
        if ($urandom_range(9) == 0)
          case ($urandom_range(3))
            0: return C_MIN;
            1: return C_MAX;
            2: return pip_pkg::coord_t'(0);
            default: return pip_pkg::coord_t'(-1);
          endcase
        return pip_pkg::coord_t'($urandom);
      end
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_vertex(input pip_pkg::pip_in_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      vtx_valid <= 1'b0;
      @(negedge clk);
    end
    vtx_valid <= 1'b1;
    vtx       <= v;
    do @(posedge clk); while (!vtx_ready);
    sb.take_vertex(v);
    vertices_sent++;
    @(negedge clk);
  endtask

  task automatic send_polygon();
    pip_pkg::coord_t  xs[8];
    pip_pkg::coord_t  ys[8];
    pip_pkg::coord_t  tx, ty;
    pip_pkg::pip_in_t v;
    int               len, mode, k, j;
    len  = $urandom_range(1, 8);
    mode = $urandom_range(2);
    for (int i = 0; i < len; i++) begin
      xs[i] = rand_coord(mode);
      ys[i] = rand_coord(mode);
    end
    k = $urandom_range(len - 1);
    j = (k + 1) % len;
    case ($urandom_range(2))
      0: begin
        tx = rand_coord(mode);
        ty = rand_coord(mode);
      end
      1: begin
        tx = xs[k];
        ty = ys[k];
      end
      default: begin
        tx = pip_pkg::coord_t'((int'(xs[k]) + int'(xs[j])) >>> 1);
        ty = pip_pkg::coord_t'((int'(ys[k]) + int'(ys[j])) >>> 1);
      end
    endcase
    for (int i = 0; i < len; i++) begin
      v.vertex_x     = xs[i];
      v.vertex_y     = ys[i];
      // point fields matter only on the first vertex; fill the rest with junk
      v.point_x      = (i == 0) ? tx : pip_pkg::coord_t'($urandom);
      v.point_y      = (i == 0) ? ty : pip_pkg::coord_t'($urandom);
      v.first_vertex = (i == 0);
      v.last_vertex  = (i == len - 1);
      send_vertex(v);
    end
  endtask

  task automatic send_noise();
    pip_pkg::pip_in_t v;
    int               mode;
    mode           = $urandom_range(2);
    v.vertex_x     = rand_coord(mode);
    v.vertex_y     = rand_coord(mode);
    v.point_x      = rand_coord(mode);
    v.point_y      = rand_coord(mode);
    v.first_vertex = $urandom_range(1);
    v.last_vertex  = $urandom_range(1);
    send_vertex(v);
  endtask

  task automatic run_phase(int n_vertices, int idle_pct, int stall_pct);
    int goal;
    send_idle_pct = idle_pct;
    res_stall_pct = stall_pct;
    goal = vertices_sent + n_vertices;
    while (vertices_sent < goal) begin
      if ($urandom_range(99) < 12)
        send_noise();
      else
        send_polygon();
    end
  endtask

  task automatic drain();
    vtx_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_directed();
    // stream before any first mark: continue from the cleared state
    send_vertex(mk(3 * ONE, ONE, 0, 0, 0, 0));
    send_vertex(mk(-2 * ONE, 5 * ONE, 7, 7, 0, 1));
    // one-vertex polygons, on and off the vertex
    send_vertex(mk(100, 200, 100, 200, 1, 1));
    send_vertex(mk(C_MAX, C_MIN, C_MIN, C_MAX, 1, 1));
    // unit square, point inside
    send_vertex(mk(0, 0, ONE / 2, ONE / 2, 1, 0));
    send_vertex(mk(ONE, 0, 0, 0, 0, 0));
    send_vertex(mk(ONE, ONE, 0, 0, 0, 0));
    send_vertex(mk(0, ONE, 0, 0, 0, 1));
    // same square, point on the bottom (horizontal) edge
    send_vertex(mk(0, 0, ONE / 2, 0, 1, 0));
    send_vertex(mk(ONE, 0, 0, 0, 0, 0));
    send_vertex(mk(ONE, ONE, 0, 0, 0, 0));
    send_vertex(mk(0, ONE, 0, 0, 0, 1));
    // triangle spanning the full coordinate range
    send_vertex(mk(C_MIN, C_MIN, 0, 0, 1, 0));
    send_vertex(mk(C_MAX, C_MIN, 0, 0, 0, 0));
    send_vertex(mk(0, C_MAX, 0, 0, 0, 1));
    // degenerate edge from a repeated vertex, point off everything
    send_vertex(mk(0, 0, 3 * ONE, ONE, 1, 0));
    send_vertex(mk(0, 0, 0, 0, 0, 0));
    send_vertex(mk(2 * ONE, 0, 0, 0, 0, 0));
    send_vertex(mk(ONE, 2 * ONE, 0, 0, 0, 1));
    // no first mark after a last vertex: keep going from the stored state
    send_vertex(mk(-ONE, ONE, C_MAX, C_MIN, 0, 1));
    // point on a vertical edge, right extreme of the ray
    send_vertex(mk(C_MAX, C_MIN, C_MAX, 0, 1, 0));
    send_vertex(mk(C_MAX, C_MAX, 0, 0, 0, 0));
    send_vertex(mk(C_MIN, 0, 0, 0, 0, 1));
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    vtx_valid     = 1'b0;
    vtx           = '0;
    res_ready     = 1'b0;
    hold_res      = 1'b0;
    send_idle_pct = 0;
    res_stall_pct = 0;
    cycles        = 0;
    vertices_sent = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_directed();
    drain();

    run_phase(210, 0, 0);
    drain();
    run_phase(210, 74, 0);
    drain();
    run_phase(210, 0, 74);
    drain();
    run_phase(210, 27, 27);
    drain();

    // hold results back while one-vertex polygons keep coming
    send_idle_pct = 0;
    res_stall_pct = 0;
    fork
      begin
        @(posedge clk);
        hold_res = 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_res = 1'b0;
      end
    join_none
    for (int i = 0; i < 60; i++)
      send_vertex(mk(int'(rand_coord(MODE_TINY)), int'(rand_coord(MODE_TINY)),
                     int'(rand_coord(MODE_TINY)), int'(rand_coord(MODE_TINY)), 1, 1));
    drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d vertices; checked %0d polygon results, %0d of them on a boundary.",
             vertices_sent, sb.verdicts_seen, sb.hits_seen);
    $display("Idle patterns: none, sender 74%%, receiver 74%%, both 27%%, plus a %0d-cycle hold.",
             HOLD_LEN);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
